// ===== design/hrlp_pkg.sv =====
package hrlp_pkg;

    localparam int OFFSET_BITS_DEF   = 16;
    localparam int VERSION_BYTES_DEF = 8;

    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_G  = 8'h47;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_O  = 8'h4f;
    localparam logic [7:0] CH_S  = 8'h53;

    localparam logic [2:0] LEN_GET  = 3'd3;
    localparam logic [2:0] LEN_POST = 3'd4;

    localparam logic METHOD_GET  = 1'b0;
    localparam logic METHOD_POST = 1'b1;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_METHOD  = 3'd1;
    localparam logic [2:0] PH_SKIP1   = 3'd2;
    localparam logic [2:0] PH_PATH    = 3'd3;
    localparam logic [2:0] PH_SKIP2   = 3'd4;
    localparam logic [2:0] PH_VERSION = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_METH  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_VER_TRUNC = 2'd3;

    typedef struct packed {
        logic       bad;
        logic       method;
        logic [2:0] pos_next;
        logic       done;
    } match_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_LF);
    endfunction

endpackage

// ===== design/hrlp_method_match.sv =====
module hrlp_method_match
(
    input  logic [2:0]            match_pos,
    input  logic                  method_seen,
    input  logic [7:0]            byte_in,
    output hrlp_pkg::match_t      result
);
    import hrlp_pkg::*;

    logic [7:0] expect_char;
    logic [2:0] word_len;

    always_comb
    begin
        word_len = method_seen ? LEN_POST : LEN_GET;
        case (match_pos)
            3'd1:    expect_char = method_seen ? CH_O : CH_E;
            3'd2:    expect_char = method_seen ? CH_S : CH_T;
            3'd3:    expect_char = CH_T;
            default: expect_char = CH_T;
        endcase
    end

    always_comb
    begin
        result.pos_next = match_pos + 3'd1;
        result.method   = method_seen;
        result.bad      = 1'b0;
        result.done     = 1'b0;
        if (match_pos == 3'd0)
        begin
            if (byte_in == CH_G)
            begin
                result.method = METHOD_GET;
            end
            else if (byte_in == CH_P)
            begin
                result.method = METHOD_POST;
            end
            else
            begin
                result.bad = 1'b1;
            end
        end
        else
        begin
            result.bad  = (match_pos >= word_len) || (byte_in != expect_char);
            result.done = (result.pos_next == word_len);
        end
    end

endmodule

// ===== design/http_request_line_parser_core.sv =====
// Request line parser: takes one byte of an HTTP request per cycle (start_req marks
// the first byte) and returns one request summary per request line: method, path
// offset/length, up to VERSION_BYTES version bytes and a status. Throughput is one
// byte per clock while in_ready is high. A summary appears in the cycle after the
// byte that ends it (space or CR after the version, CR before it, bad method byte).
// The single output register is the only stall point: in_ready drops only while a
// summary is held there and out_ready is low. Byte offsets: OFFSET_BITS, saturating.
module http_request_line_parser_core
#(
    parameter int OFFSET_BITS   = hrlp_pkg::OFFSET_BITS_DEF,
    parameter int VERSION_BYTES = hrlp_pkg::VERSION_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        method,
    output logic [15:0] path_offset,
    output logic [15:0] path_length,
    output logic [63:0] version_text,
    output logic [3:0]  version_length,
    output logic [1:0]  status
);
    import hrlp_pkg::*;

    localparam int VC_BITS = $clog2(VERSION_BYTES + 2);
    localparam int VS_BITS = 8 * VERSION_BYTES;

    logic [2:0]             phase_reg,         phase_next;
    logic [2:0]             match_pos_reg,     match_pos_next;
    logic                   method_seen_reg,   method_seen_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg,   byte_offset_next;
    logic [OFFSET_BITS-1:0] path_begin_reg,    path_begin_next;
    logic [OFFSET_BITS-1:0] path_count_reg,    path_count_next;
    logic [VS_BITS-1:0]     version_store_reg, version_store_next;
    logic [VC_BITS-1:0]     version_count_reg, version_count_next;
    logic                   offset_full_reg,   offset_full_next;
    logic                   too_long_reg,      too_long_next;

    logic                   out_valid_reg;
    logic                   method_reg,    method_next;
    logic [15:0]            path_off_reg,  path_off_next;
    logic [15:0]            path_sz_reg,   path_sz_next;
    logic [63:0]            ver_text_reg,  ver_text_next;
    logic [3:0]             ver_len_reg,   ver_len_next;
    logic [1:0]             status_reg,    status_next;

    logic                   in_fire;
    logic                   emit;
    logic [2:0]             mpos_eff;
    logic                   mseen_eff;
    match_t                 match;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign mpos_eff  = start_req ? 3'd0 : match_pos_reg;
    assign mseen_eff = start_req ? 1'b0 : method_seen_reg;

    hrlp_method_match u_match
    (
        .match_pos   (mpos_eff),
        .method_seen (mseen_eff),
        .byte_in     (byte_in),
        .result      (match)
    );

    always_comb
    begin
        logic                   line_end;
        logic                   keep_ver;
        logic [OFFSET_BITS-1:0] cur;
        phase_next         = phase_reg;
        match_pos_next     = match_pos_reg;
        method_seen_next   = method_seen_reg;
        byte_offset_next   = byte_offset_reg;
        path_begin_next    = path_begin_reg;
        path_count_next    = path_count_reg;
        version_store_next = version_store_reg;
        version_count_next = version_count_reg;
        offset_full_next   = offset_full_reg;
        too_long_next      = too_long_reg;
        emit               = 1'b0;
        line_end           = 1'b0;
        keep_ver           = 1'b0;
        cur                = byte_offset_reg;
        method_next        = METHOD_GET;
        path_off_next      = 16'd0;
        path_sz_next       = 16'd0;
        ver_text_next      = 64'd0;
        ver_len_next       = 4'd0;
        status_next        = ST_BAD_METH;

        if (in_fire)
        begin
            if (start_req)
            begin
                phase_next         = PH_METHOD;
                match_pos_next     = 3'd0;
                method_seen_next   = 1'b0;
                byte_offset_next   = '0;
                path_begin_next    = '0;
                path_count_next    = '0;
                version_store_next = '0;
                version_count_next = '0;
                offset_full_next   = 1'b0;
                too_long_next      = 1'b0;
            end
            if (phase_next != PH_IDLE && phase_next != PH_DONE)
            begin
                if (offset_full_next)
                begin
                    too_long_next = 1'b1;
                end
                cur = byte_offset_next;
                if (&byte_offset_next)
                begin
                    offset_full_next = 1'b1;
                end
                else
                begin
                    byte_offset_next = byte_offset_next + OFFSET_BITS'(1);
                end

                case (phase_next)
                    PH_METHOD:
                    begin
                        if (match.bad)
                        begin
                            emit       = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            method_seen_next = match.method;
                            match_pos_next   = match.pos_next;
                            if (match.done)
                            begin
                                phase_next = PH_SKIP1;
                            end
                        end
                    end
                    PH_SKIP1:
                    begin
                        if (!is_blank(byte_in))
                        begin
                            path_begin_next = cur;
                            path_count_next = OFFSET_BITS'(1);
                            phase_next      = PH_PATH;
                        end
                    end
                    PH_PATH:
                    begin
                        if (byte_in == CH_SP)
                        begin
                            phase_next = PH_SKIP2;
                        end
                        else if (!(&path_count_next))
                        begin
                            path_count_next = path_count_next + OFFSET_BITS'(1);
                        end
                    end
                    PH_SKIP2:
                    begin
                        if (byte_in == CH_CR)
                        begin
                            line_end = 1'b1;
                        end
                        else if (!is_blank(byte_in))
                        begin
                            keep_ver   = 1'b1;
                            phase_next = PH_VERSION;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (byte_in == CH_SP || byte_in == CH_CR)
                        begin
                            line_end = 1'b1;
                        end
                        else
                        begin
                            keep_ver = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (keep_ver)
                begin
                    if (version_count_next < VC_BITS'(VERSION_BYTES))
                    begin
                        for (int i = 0; i < VERSION_BYTES; i++)
                        begin
                            if (version_count_next == VC_BITS'(i))
                            begin
                                version_store_next[i*8 +: 8] = byte_in;
                            end
                        end
                        version_count_next = version_count_next + VC_BITS'(1);
                    end
                    else
                    begin
                        version_count_next = VC_BITS'(VERSION_BYTES + 1);
                    end
                end

                if (line_end)
                begin
                    emit          = 1'b1;
                    phase_next    = PH_DONE;
                    method_next   = method_seen_next;
                    path_off_next = 16'(path_begin_next);
                    path_sz_next  = 16'(path_count_next);
                    ver_text_next = 64'(version_store_next);
                    if (version_count_next > VC_BITS'(VERSION_BYTES))
                    begin
                        ver_len_next = 4'(VERSION_BYTES);
                    end
                    else
                    begin
                        ver_len_next = 4'(version_count_next);
                    end
                    if (too_long_next)
                    begin
                        status_next = ST_TOO_LONG;
                    end
                    else if (version_count_next > VC_BITS'(VERSION_BYTES))
                    begin
                        status_next = ST_VER_TRUNC;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            match_pos_reg     <= 3'd0;
            method_seen_reg   <= 1'b0;
            byte_offset_reg   <= '0;
            path_begin_reg    <= '0;
            path_count_reg    <= '0;
            version_store_reg <= '0;
            version_count_reg <= '0;
            offset_full_reg   <= 1'b0;
            too_long_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            match_pos_reg     <= match_pos_next;
            method_seen_reg   <= method_seen_next;
            byte_offset_reg   <= byte_offset_next;
            path_begin_reg    <= path_begin_next;
            path_count_reg    <= path_count_next;
            version_store_reg <= version_store_next;
            version_count_reg <= version_count_next;
            offset_full_reg   <= offset_full_next;
            too_long_reg      <= too_long_next;
            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            method_reg   <= method_next;
            path_off_reg <= path_off_next;
            path_sz_reg  <= path_sz_next;
            ver_text_reg <= ver_text_next;
            ver_len_reg  <= ver_len_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign method         = method_reg;
    assign path_offset    = path_off_reg;
    assign path_length    = path_sz_reg;
    assign version_text   = ver_text_reg;
    assign version_length = ver_len_reg;
    assign status         = status_reg;

endmodule

// ===== design/hrlp_checker.sv =====
module hrlp_checker
#(
    parameter int VERSION_BYTES = hrlp_pkg::VERSION_BYTES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        method,
    input logic [15:0] path_offset,
    input logic [15:0] path_length,
    input logic [63:0] version_text,
    input logic [3:0]  version_length,
    input logic [1:0]  status
);
    import hrlp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("request dropped while stalled");

    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("request appeared without an accepted byte");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_BAD_METH |->
            path_offset == 16'd0 && path_length == 16'd0 &&
            version_text == 64'd0 && version_length == 4'd0 && method == METHOD_GET)
        else $error("bad method request carries data");

    a_ver_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_VER_TRUNC |-> version_length == 4'(VERSION_BYTES))
        else $error("truncated version length mismatch");

endmodule

bind http_request_line_parser_core hrlp_checker #(.VERSION_BYTES(VERSION_BYTES)) u_hrlp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .method         (method),
    .path_offset    (path_offset),
    .path_length    (path_length),
    .version_text   (version_text),
    .version_length (version_length),
    .status         (status)
);
